@@ sv/pnsm_pkg.sv @@
// Shared types and constants for the peak-normalized sample mixer.
package pnsm_pkg;

    // Field and state widths.
    localparam int SAMPLE_W = 24;
    localparam int ACC_W    = 29;
    localparam int PEAK_W   = 28;
    localparam int GAIN_W   = 32;
    localparam int FS_W     = 23;

    // Divider geometry: a 54-bit dividend, a 28-bit divisor and a 32-bit quotient.
    localparam int DVD_W = 54;
    localparam int DEN_W = 28;
    localparam int QUO_W = 32;

    // Full-scale values and unity gain in Q1.31.
    localparam logic [FS_W-1:0]   FS24       = 23'd8388607;
    localparam logic [FS_W-1:0]   FS16       = 23'd32767;
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 32'h8000_0000;

    // Operation codes carried by an input word.
    typedef enum logic [1:0] {
        OP_MEASURE = 2'd0,
        OP_WRITE   = 2'd1,
        OP_FINISH  = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // Kinds of output word.
    localparam logic RESULT_SAMPLE = 1'b0;
    localparam logic RESULT_GAIN   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv_start;
        logic fin_start;
        logic acc;
        logic peak;
        logic scale;
        logic sum_clear;
        logic gain_set;
        logic clear_all;
        logic emit;
        logic emit_kind;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic last;
        logic peak_gt_fs;
        logic out_free;
    } t_dp_status;

endpackage

@@ sv/peak_normalized_sample_mixer.sv @@
// Top level: peak-normalized sample mixer, controller plus datapath.
// One word at a time. A source word is converted to the output depth and accumulated;
// one that closes a measure sample then updates the peak, one that closes a write
// sample is scaled and emits its mixed sample. Finish emits the gain word, computed by
// the gain divider when the peak exceeds full scale; clear resets sum, count, peak and gain.
// Synchronous active-low reset clears sum, count and peak, sets unity gain, 16-bit output.
module peak_normalized_sample_mixer #(
    parameter int MAX_SOURCES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_op,
    input  logic signed [pnsm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_source_is_24bit,
    input  logic                                 i_last_source,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_result_kind,
    output logic signed [pnsm_pkg::SAMPLE_W-1:0] o_mixed_sample,
    output logic [pnsm_pkg::GAIN_W-1:0]          o_gain_value
);

    pnsm_pkg::t_dp_cmd    cmd;
    pnsm_pkg::t_dp_status status;
    logic                 cfg_we;

    assign cfg_we = i_cfg_valid && o_cfg_ready;

    pnsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (pnsm_pkg::t_op'(i_op)),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pnsm_dp #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_sample          (i_sample),
        .i_source_is_24bit (i_source_is_24bit),
        .i_last_source     (i_last_source),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_result_kind     (o_result_kind),
        .o_mixed_sample    (o_mixed_sample),
        .o_gain_value      (o_gain_value)
    );

endmodule

@@ sv/pnsm_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module pnsm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pnsm_pkg::DVD_W-1:0]    i_dividend,
    input  logic [pnsm_pkg::DEN_W-1:0]    i_divisor,
    output logic                          o_last,
    output logic [pnsm_pkg::QUO_W-1:0]    o_quotient
);

    localparam int SW = $clog2(pnsm_pkg::QUO_W);
    localparam logic [SW-1:0] LAST_STEP = SW'(pnsm_pkg::QUO_W - 1);

    logic                         r_busy;
    logic [SW-1:0]                r_step;
    logic [pnsm_pkg::DEN_W-1:0]   r_rem;
    logic [pnsm_pkg::DEN_W-1:0]   r_den;
    logic [pnsm_pkg::QUO_W-1:0]   r_quo;
    logic [pnsm_pkg::DEN_W:0]     trial;
    logic [pnsm_pkg::DEN_W:0]     diff;
    logic                         fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        trial = {r_rem, r_quo[pnsm_pkg::QUO_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = trial >= {1'b0, r_den};
    end

    // Step counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + SW'(1);
            if (r_step == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The quotient register starts as the low dividend bits and fills with quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= pnsm_pkg::DEN_W'(i_dividend[pnsm_pkg::DVD_W-1:pnsm_pkg::QUO_W]);
            r_quo <= i_dividend[pnsm_pkg::QUO_W-1:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[pnsm_pkg::DEN_W-1:0] : trial[pnsm_pkg::DEN_W-1:0];
            r_quo <= {r_quo[pnsm_pkg::QUO_W-2:0], fits};
        end
    end

    assign o_last     = r_busy && (r_step == LAST_STEP);
    assign o_quotient = r_quo;

    // A new division never starts on top of one in flight.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    // The last step ends the division.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_last && !i_start) |=> !r_busy)
        else $error("divider still busy after its last step");

endmodule

@@ sv/pnsm_dp.sv @@
// Datapath: depth conversion, accumulator, peak and gain registers, output register.
module pnsm_dp #(
    parameter int MAX_SOURCES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_data,
    input  logic signed [pnsm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_source_is_24bit,
    input  logic                                 i_last_source,
    input  pnsm_pkg::t_dp_cmd                    i_cmd,
    output pnsm_pkg::t_dp_status                 o_status,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic                                 o_result_kind,
    output logic signed [pnsm_pkg::SAMPLE_W-1:0] o_mixed_sample,
    output logic [pnsm_pkg::GAIN_W-1:0]          o_gain_value
);

    localparam int CW = $clog2(MAX_SOURCES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SOURCES);
    localparam logic signed [33:0] ACC_HI = 34'sd268435455;
    localparam logic signed [33:0] ACC_LO = -34'sd268435456;

    // Architectural state.
    logic                                 r_out24;
    logic signed [pnsm_pkg::ACC_W-1:0]    r_sum;
    logic [CW-1:0]                        r_cnt;
    logic [pnsm_pkg::PEAK_W-1:0]          r_peak;
    logic [pnsm_pkg::GAIN_W-1:0]          r_gain;

    // Captured word and intermediate registers.
    logic [pnsm_pkg::SAMPLE_W-1:0]        r_mag;
    logic                                 r_src24;
    logic                                 r_last;
    logic                                 r_neg;
    logic [31:0]                          r_conv_mag;
    logic [60:0]                          r_prod;
    logic                                 r_prod_neg;

    // Output register.
    logic                                 r_out_valid;
    logic                                 r_out_kind;
    logic signed [pnsm_pkg::SAMPLE_W-1:0] r_out_sample;
    logic [pnsm_pkg::GAIN_W-1:0]          r_out_gain;

    logic [pnsm_pkg::FS_W-1:0]            fs;
    logic [pnsm_pkg::SAMPLE_W-1:0]        in_mag;
    logic [31:0]                          up_x;
    logic [16:0]                          up_t;
    logic [1:0]                           up_fix;
    logic [31:0]                          up_mag;
    logic [38:0]                          dn_x;
    logic [23:0]                          dn_t;
    logic [15:0]                          dn_mag;
    logic [31:0]                          conv_mag;
    logic                                 div_start;
    logic [pnsm_pkg::DVD_W-1:0]           div_dividend;
    logic [pnsm_pkg::DEN_W-1:0]           div_divisor;
    logic                                 div_last;
    logic [pnsm_pkg::QUO_W-1:0]           quotient;
    logic [32:0]                          conv_ext;
    logic signed [32:0]                   conv_val;
    logic signed [33:0]                   acc_sum;
    logic signed [pnsm_pkg::ACC_W-1:0]    acc_sat;
    logic                                 cnt_open;
    logic [pnsm_pkg::ACC_W-1:0]           sum_mag;
    logic [pnsm_pkg::PEAK_W-1:0]          peak_cand;
    logic [60:0]                          scale_prod;
    logic [29:0]                          scaled;
    logic [pnsm_pkg::FS_W-1:0]            sat_mag;
    logic [pnsm_pkg::SAMPLE_W-1:0]        sat_ext;
    logic [pnsm_pkg::SAMPLE_W-1:0]        out_val;
    logic                                 out_free;

    // Full scale follows the output depth.
    always_comb begin
        fs = r_out24 ? pnsm_pkg::FS24 : pnsm_pkg::FS16;
    end

    // Magnitude of the incoming sample, captured with the word.
    always_comb begin
        in_mag = i_sample[pnsm_pkg::SAMPLE_W-1] ? pnsm_pkg::SAMPLE_W'(-i_sample)
                                                : pnsm_pkg::SAMPLE_W'(i_sample);
    end

    // Depth conversion on the magnitude. Up: m*(2^23-1)/(2^15-1) = 256*m + 255*m/(2^15-1).
    // Down: m*(2^15-1)/(2^23-1). Each division by 2^k-1 folds the high part onto the
    // low part and fixes the quotient with one or two compares.
    always_comb begin
        up_x = {r_mag, 8'b0} - 32'(r_mag);
        up_t = up_x[31:15] + 17'(up_x[14:0]);
        if (up_t >= 17'd65534) begin
            up_fix = 2'd2;
        end else if (up_t >= 17'd32767) begin
            up_fix = 2'd1;
        end else begin
            up_fix = 2'd0;
        end
        up_mag = {r_mag, 8'b0} + 32'(up_x[31:15]) + 32'(up_fix);
        dn_x   = {r_mag, 15'b0} - 39'(r_mag);
        dn_t   = 24'(dn_x[38:23]) + {1'b0, dn_x[22:0]};
        dn_mag = dn_x[38:23] + 16'(dn_t >= 24'd8388607);
        if (r_src24 == r_out24) begin
            conv_mag = 32'(r_mag);
        end else if (r_out24) begin
            conv_mag = up_mag;
        end else begin
            conv_mag = 32'(dn_mag);
        end
    end

    // The divider computes the gain on finish.
    always_comb begin
        div_start    = i_cmd.fin_start;
        div_dividend = {fs, 31'b0};
        div_divisor  = r_peak;
    end

    pnsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_last     (div_last),
        .o_quotient (quotient)
    );

    // Signed contribution and the saturating accumulator add.
    always_comb begin
        conv_ext = {1'b0, r_conv_mag};
        conv_val = r_neg ? -$signed(conv_ext) : $signed(conv_ext);
        acc_sum  = $signed({{5{r_sum[pnsm_pkg::ACC_W-1]}}, r_sum})
                 + $signed({conv_val[32], conv_val});
        if (acc_sum > ACC_HI) begin
            acc_sat = ACC_HI[pnsm_pkg::ACC_W-1:0];
        end else if (acc_sum < ACC_LO) begin
            acc_sat = ACC_LO[pnsm_pkg::ACC_W-1:0];
        end else begin
            acc_sat = acc_sum[pnsm_pkg::ACC_W-1:0];
        end
        cnt_open = r_cnt < MAX_CNT;
    end

    // Magnitude of the finished sum, for the peak and for scaling.
    always_comb begin
        sum_mag    = r_sum[pnsm_pkg::ACC_W-1] ? pnsm_pkg::ACC_W'(-r_sum)
                                              : pnsm_pkg::ACC_W'(r_sum);
        peak_cand  = sum_mag[pnsm_pkg::ACC_W-1] ? '1 : sum_mag[pnsm_pkg::PEAK_W-1:0];
        scale_prod = 61'(sum_mag) * 61'(r_gain);
    end

    // Scaled sample: drop the Q1.31 fraction, clip to full scale, restore the sign.
    always_comb begin
        scaled  = r_prod[60:31];
        sat_mag = (scaled > {7'b0, fs}) ? fs : scaled[pnsm_pkg::FS_W-1:0];
        sat_ext = {1'b0, sat_mag};
        out_val = r_prod_neg ? pnsm_pkg::SAMPLE_W'(-sat_ext) : sat_ext;
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out24     <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_peak      <= '0;
            r_gain      <= pnsm_pkg::UNITY_GAIN;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_out24 <= i_cfg_data;
            end
            if (i_cmd.clear_all) begin
                r_sum  <= '0;
                r_cnt  <= '0;
                r_peak <= '0;
                r_gain <= pnsm_pkg::UNITY_GAIN;
            end else begin
                // Contributions past the source limit are dropped.
                priority if (i_cmd.sum_clear) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else if (i_cmd.acc && cnt_open) begin
                    r_sum <= acc_sat;
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_sum <= r_sum;
                    r_cnt <= r_cnt;
                end
                if (i_cmd.peak && (peak_cand > r_peak)) begin
                    r_peak <= peak_cand;
                end
                if (i_cmd.gain_set) begin
                    r_gain <= o_status.peak_gt_fs ? quotient : pnsm_pkg::UNITY_GAIN;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag   <= in_mag;
            r_src24 <= i_source_is_24bit;
            r_last  <= i_last_source;
            r_neg   <= i_sample[pnsm_pkg::SAMPLE_W-1];
        end
        if (i_cmd.conv_start) begin
            r_conv_mag <= conv_mag;
        end
        if (i_cmd.scale) begin
            r_prod     <= scale_prod;
            r_prod_neg <= r_sum[pnsm_pkg::ACC_W-1];
        end
        if (i_cmd.emit) begin
            r_out_kind   <= i_cmd.emit_kind;
            r_out_sample <= (i_cmd.emit_kind == pnsm_pkg::RESULT_GAIN) ? '0 : $signed(out_val);
            r_out_gain   <= r_gain;
        end
    end

    always_comb begin
        o_status.div_last   = div_last;
        o_status.last       = r_last;
        o_status.peak_gt_fs = r_peak > {5'b0, fs};
        o_status.out_free   = out_free;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_mixed_sample = r_out_sample;
    assign o_gain_value   = r_out_gain;

    // The contribution count never passes the source limit.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("contribution count beyond source limit");

    // The gain only ever attenuates.
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= pnsm_pkg::UNITY_GAIN)
        else $error("gain above unity");

endmodule

@@ sv/pnsm_ctrl.sv @@
// Controller state machine that sequences one word at a time through the datapath.
module pnsm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  pnsm_pkg::t_op        i_op,
    output logic                 o_in_stall,
    output logic                 o_cfg_ready,
    input  pnsm_pkg::t_dp_status i_status,
    output pnsm_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_CONV  = 10'b00_0000_0010,
        S_DIV   = 10'b00_0000_0100,
        S_ACC   = 10'b00_0000_1000,
        S_PEAK  = 10'b00_0001_0000,
        S_SCALE = 10'b00_0010_0000,
        S_FIN   = 10'b00_0100_0000,
        S_GAIN  = 10'b00_1000_0000,
        S_CLR   = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    pnsm_pkg::t_op r_op;
    pnsm_pkg::t_op n_op;
    logic          accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_op       = i_op;
                    unique case (i_op)
                        pnsm_pkg::OP_MEASURE,
                        pnsm_pkg::OP_WRITE:  n_state = S_CONV;
                        pnsm_pkg::OP_FINISH: n_state = S_FIN;
                        pnsm_pkg::OP_CLEAR:  n_state = S_CLR;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_CONV: begin
                // Bring the sample to the output depth and hold it for the add.
                o_cmd.conv_start = 1'b1;
                n_state          = S_ACC;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_GAIN;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (!i_status.last) begin
                    n_state = S_IDLE;
                end else if (r_op == pnsm_pkg::OP_MEASURE) begin
                    n_state = S_PEAK;
                end else begin
                    n_state = S_SCALE;
                end
            end
            S_PEAK: begin
                o_cmd.peak      = 1'b1;
                o_cmd.sum_clear = 1'b1;
                n_state         = S_IDLE;
            end
            S_SCALE: begin
                o_cmd.scale     = 1'b1;
                o_cmd.sum_clear = 1'b1;
                n_state         = S_EMIT;
            end
            S_FIN: begin
                // Only a peak above full scale needs a division.
                o_cmd.sum_clear = 1'b1;
                o_cmd.fin_start = i_status.peak_gt_fs;
                n_state         = i_status.peak_gt_fs ? S_DIV : S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain_set = 1'b1;
                n_state        = S_EMIT;
            end
            S_CLR: begin
                o_cmd.clear_all = 1'b1;
                n_state         = S_IDLE;
            end
            S_EMIT: begin
                o_cmd.emit_kind = (r_op == pnsm_pkg::OP_FINISH) ? pnsm_pkg::RESULT_GAIN
                                                                : pnsm_pkg::RESULT_SAMPLE;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= pnsm_pkg::OP_MEASURE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    // A word is only loaded into the output register when that register is free.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("output word overwritten");

    // An accepted word keeps the input side closed on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word taken while one is in progress");

endmodule
